// ===== rtl/core/lcabl_pkg.sv =====
// Shared types and constants for the binary-lifting common-ancestor block.
`default_nettype none

package lcabl_pkg;

   // Fixed field widths of the request and response words.
   localparam int FIELD_WIDTH = 10;
   localparam int OP_WIDTH    = 2;

   // Default sizing of the tree tables.
   localparam int DEFAULT_MAX_NODES   = 1024;
   localparam int DEFAULT_LIFT_LEVELS = 10;

   // Request operation codes.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_RUN,
      ST_BUILD_DRAIN,
      ST_QUERY_ORDER,
      ST_QUERY_UP,
      ST_QUERY_DOWN,
      ST_QUERY_LAST
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/core/lcabl_ram.sv =====
// Synchronous RAM with one write port and two registered read ports.
`default_nettype none

module lcabl_ram #(
   parameter int WIDTH = lcabl_pkg::FIELD_WIDTH,
   parameter int DEPTH = lcabl_pkg::DEFAULT_MAX_NODES
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr0,
   output logic      [WIDTH-1:0]         rd_data0,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr1,
   output logic      [WIDTH-1:0]         rd_data1
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Read ports return the old contents on a same-address write.
   always_ff @(posedge clock) begin
      rd_data0_ff <= ram_ff[rd_addr0];
      rd_data1_ff <= ram_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lcabl_seq.sv =====
// Sequencer and datapath that load, build and walk the lifting tables.
`default_nettype none

module lcabl_seq #(
   parameter int MAX_NODES   = lcabl_pkg::DEFAULT_MAX_NODES,
   parameter int LIFT_LEVELS = lcabl_pkg::DEFAULT_LIFT_LEVELS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [lcabl_pkg::OP_WIDTH-1:0]      op,
   input  wire logic [$clog2(MAX_NODES)-1:0]        node_idx,
   input  wire logic [$clog2(MAX_NODES)-1:0]        parent_idx,
   input  wire logic [lcabl_pkg::FIELD_WIDTH-1:0]   depth,
   input  wire logic [$clog2(MAX_NODES)-1:0]        other_idx,
   output logic                                     busy,
   output logic                                     rsp_valid,
   output logic      [lcabl_pkg::FIELD_WIDTH-1:0]   rsp_ancestor
);

   localparam int FW        = lcabl_pkg::FIELD_WIDTH;
   localparam int AW        = $clog2(MAX_NODES);
   localparam int LW        = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam int ANC_DEPTH = LIFT_LEVELS * MAX_NODES;
   localparam int ANC_AW    = $clog2(ANC_DEPTH);

   // Ancestor table address: one block of MAX_NODES entries per level.
   function automatic logic [ANC_AW-1:0] anc_addr(input logic [LW-1:0] lvl,
                                                  input logic [AW-1:0] idx);
      anc_addr = ANC_AW'(lvl) * ANC_AW'(MAX_NODES) + ANC_AW'(idx);
   endfunction

   lcabl_pkg::state_type state_ff, state_in;

   logic [AW-1:0] a_ff, a_in;
   logic [AW-1:0] b_ff, b_in;
   logic [FW-1:0] diff_ff, diff_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [AW-1:0] bnode_ff, bnode_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [AW-1:0] s1_node_ff, s1_node_in;
   logic          s2_valid_ff, s2_valid_in;
   logic [AW-1:0] s2_node_ff, s2_node_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_ancestor_ff, rsp_ancestor_in;

   // Memory ports.
   logic              anc_we;
   logic [ANC_AW-1:0] anc_waddr;
   logic [AW-1:0]     anc_wdata;
   logic [ANC_AW-1:0] anc_raddr0;
   logic [ANC_AW-1:0] anc_raddr1;
   logic [AW-1:0]     anc_rd0;
   logic [AW-1:0]     anc_rd1;
   logic              dep_we;
   logic [FW-1:0]     dep_rd0;
   logic [FW-1:0]     dep_rd1;

   // Shared decode.
   logic          accept;
   logic          lvl_top;
   logic          lvl_zero;
   logic          build_last;
   logic          swap;
   logic [AW-1:0] ord_a;
   logic [AW-1:0] ord_b;
   logic [FW-1:0] ord_diff;
   logic [AW-1:0] b_up;
   logic          lift_differ;
   logic [AW-1:0] a_dn;
   logic [AW-1:0] b_dn;

   // Level 0 holds parents; higher levels hold 2^k-th ancestors.
   lcabl_ram #(
      .WIDTH (AW),
      .DEPTH (ANC_DEPTH)
   ) u_anc_ram (
      .clock    (clock),
      .wr_en    (anc_we),
      .wr_addr  (anc_waddr),
      .wr_data  (anc_wdata),
      .rd_addr0 (anc_raddr0),
      .rd_data0 (anc_rd0),
      .rd_addr1 (anc_raddr1),
      .rd_data1 (anc_rd1)
   );

   // Node depths, read for both query nodes in the accept cycle.
   lcabl_ram #(
      .WIDTH (FW),
      .DEPTH (MAX_NODES)
   ) u_depth_ram (
      .clock    (clock),
      .wr_en    (dep_we),
      .wr_addr  (node_idx),
      .wr_data  (depth),
      .rd_addr0 (node_idx),
      .rd_data0 (dep_rd0),
      .rd_addr1 (other_idx),
      .rd_data1 (dep_rd1)
   );

   assign busy       = (state_ff != lcabl_pkg::ST_IDLE);
   assign accept     = start && !busy;
   assign lvl_top    = (lvl_ff == LW'(LIFT_LEVELS - 1));
   assign lvl_zero   = (lvl_ff == '0);
   assign build_last = (bnode_ff == AW'(MAX_NODES - 1));

   // Put the shallower node in a, and take the depth difference.
   assign swap     = (dep_rd0 > dep_rd1);
   assign ord_a    = swap ? b_ff : a_ff;
   assign ord_b    = swap ? a_ff : b_ff;
   assign ord_diff = swap ? (dep_rd0 - dep_rd1) : (dep_rd1 - dep_rd0);

   // One lifting step of the deeper node per difference bit.
   assign b_up = diff_ff[0] ? anc_rd0 : b_ff;

   // Joint lift while the two ancestors differ.
   assign lift_differ = (anc_rd0 != anc_rd1);
   assign a_dn        = lift_differ ? anc_rd0 : a_ff;
   assign b_dn        = lift_differ ? anc_rd1 : b_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcabl_pkg::ST_IDLE: begin
            if (accept) begin
               case (op)
                  lcabl_pkg::OP_BUILD: begin
                     state_in = (LIFT_LEVELS > 1) ? lcabl_pkg::ST_BUILD_RUN
                                                  : lcabl_pkg::ST_IDLE;
                  end
                  lcabl_pkg::OP_QUERY: state_in = lcabl_pkg::ST_QUERY_ORDER;
                  default:             state_in = lcabl_pkg::ST_IDLE;
               endcase
            end
         end
         lcabl_pkg::ST_BUILD_RUN: begin
            if (build_last) begin
               state_in = lcabl_pkg::ST_BUILD_DRAIN;
            end
         end
         lcabl_pkg::ST_BUILD_DRAIN: begin
            if (!s1_valid_ff) begin
               state_in = lvl_top ? lcabl_pkg::ST_IDLE : lcabl_pkg::ST_BUILD_RUN;
            end
         end
         lcabl_pkg::ST_QUERY_ORDER: state_in = lcabl_pkg::ST_QUERY_UP;
         lcabl_pkg::ST_QUERY_UP: begin
            if (lvl_top) begin
               state_in = (a_ff == b_up) ? lcabl_pkg::ST_IDLE
                                         : lcabl_pkg::ST_QUERY_DOWN;
            end
         end
         lcabl_pkg::ST_QUERY_DOWN: begin
            if (lvl_zero) begin
               state_in = lcabl_pkg::ST_QUERY_LAST;
            end
         end
         lcabl_pkg::ST_QUERY_LAST: state_in = lcabl_pkg::ST_IDLE;
         default:                  state_in = lcabl_pkg::ST_IDLE;
      endcase
   end

   // Datapath, memory controls and response.
   always_comb begin
      a_in            = a_ff;
      b_in            = b_ff;
      diff_in         = diff_ff;
      lvl_in          = lvl_ff;
      bnode_in        = bnode_ff;
      rsp_valid_in    = 1'b0;
      rsp_ancestor_in = rsp_ancestor_ff;
      anc_raddr0      = anc_addr(lvl_ff, b_ff);
      anc_raddr1      = anc_addr(lvl_ff, a_ff);

      // Build pipeline: read the mid node, then its ancestor, then write.
      s1_valid_in = (state_ff == lcabl_pkg::ST_BUILD_RUN);
      s1_node_in  = bnode_ff;
      s2_valid_in = s1_valid_ff;
      s2_node_in  = s1_node_ff;

      // The write port serves build write-back, otherwise loads.
      if (s2_valid_ff) begin
         anc_we    = 1'b1;
         anc_waddr = anc_addr(lvl_ff, s2_node_ff);
         anc_wdata = anc_rd1;
      end else begin
         anc_we    = accept && (op == lcabl_pkg::OP_LOAD);
         anc_waddr = anc_addr('0, node_idx);
         anc_wdata = parent_idx;
      end
      dep_we = accept && (op == lcabl_pkg::OP_LOAD);

      unique case (state_ff)
         lcabl_pkg::ST_IDLE: begin
            if (accept && (op == lcabl_pkg::OP_BUILD)) begin
               lvl_in   = LW'(1);
               bnode_in = '0;
            end
            if (accept && (op == lcabl_pkg::OP_QUERY)) begin
               a_in = node_idx;
               b_in = other_idx;
            end
         end
         lcabl_pkg::ST_BUILD_RUN: begin
            anc_raddr0 = anc_addr(lvl_ff - LW'(1), bnode_ff);
            anc_raddr1 = anc_addr(lvl_ff - LW'(1), anc_rd0);
            bnode_in   = bnode_ff + AW'(1);
         end
         lcabl_pkg::ST_BUILD_DRAIN: begin
            anc_raddr1 = anc_addr(lvl_ff - LW'(1), anc_rd0);
            if (!s1_valid_ff) begin
               lvl_in   = lvl_ff + LW'(1);
               bnode_in = '0;
            end
         end
         lcabl_pkg::ST_QUERY_ORDER: begin
            a_in       = ord_a;
            b_in       = ord_b;
            diff_in    = ord_diff;
            lvl_in     = '0;
            anc_raddr0 = anc_addr('0, ord_b);
         end
         lcabl_pkg::ST_QUERY_UP: begin
            b_in    = b_up;
            diff_in = diff_ff >> 1;
            if (lvl_top) begin
               if (a_ff == b_up) begin
                  rsp_valid_in    = 1'b1;
                  rsp_ancestor_in = FW'(a_ff);
               end
               anc_raddr0 = anc_addr(lvl_ff, a_ff);
               anc_raddr1 = anc_addr(lvl_ff, b_up);
            end else begin
               lvl_in     = lvl_ff + LW'(1);
               anc_raddr0 = anc_addr(lvl_ff + LW'(1), b_up);
            end
         end
         lcabl_pkg::ST_QUERY_DOWN: begin
            a_in = a_dn;
            b_in = b_dn;
            if (lvl_zero) begin
               anc_raddr0 = anc_addr('0, a_dn);
            end else begin
               lvl_in     = lvl_ff - LW'(1);
               anc_raddr0 = anc_addr(lvl_ff - LW'(1), a_dn);
               anc_raddr1 = anc_addr(lvl_ff - LW'(1), b_dn);
            end
         end
         lcabl_pkg::ST_QUERY_LAST: begin
            rsp_valid_in    = 1'b1;
            rsp_ancestor_in = FW'(anc_rd0);
         end
         default: begin
            lvl_in = lvl_ff;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcabl_pkg::ST_IDLE;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      a_ff            <= a_in;
      b_ff            <= b_in;
      diff_ff         <= diff_in;
      lvl_ff          <= lvl_in;
      bnode_ff        <= bnode_in;
      s1_node_ff      <= s1_node_in;
      s2_node_ff      <= s2_node_in;
      rsp_ancestor_ff <= rsp_ancestor_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;

`ifndef SYNTHESIS
   // A response word only follows the end of a query walk.
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == lcabl_pkg::ST_QUERY_UP ||
                        $past(state_ff) == lcabl_pkg::ST_QUERY_LAST))
      else $error("response word without a finishing query step");

   // At most one response word per query.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("back-to-back response words");

   // Build write-back only happens while a build is running.
   a_build_wb_in_build: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (state_ff == lcabl_pkg::ST_BUILD_RUN ||
                       state_ff == lcabl_pkg::ST_BUILD_DRAIN))
      else $error("build write-back outside a build");

   // The level counter stays inside the table during a query walk.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcabl_pkg::ST_QUERY_UP || state_ff == lcabl_pkg::ST_QUERY_DOWN)
      |-> (lvl_ff <= LW'(LIFT_LEVELS - 1)))
      else $error("lifting level out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lca_binary_lifting.sv =====
// Lowest common ancestor by binary lifting: node reduction and the table sequencer.
// Query: response strobe after the order step and the upward walk, or, if the lifted node
// does not yet meet the other, after the downward walk and a last step; one level per cycle.
// The next request can be taken while the strobe is high. Load writes in the accept cycle and
// keeps busy low; build holds busy, one node per cycle, read-read-write pipe, drain per level.
// Strobes cannot be stalled; synchronous reset clears control state, tables stay undefined.
`default_nettype none

module lca_binary_lifting #(
   parameter int MAX_NODES   = lcabl_pkg::DEFAULT_MAX_NODES,
   parameter int LIFT_LEVELS = lcabl_pkg::DEFAULT_LIFT_LEVELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lcabl_pkg::OP_WIDTH-1:0]    req_op,
   input  wire logic [lcabl_pkg::FIELD_WIDTH-1:0] req_node,
   input  wire logic [lcabl_pkg::FIELD_WIDTH-1:0] req_parent,
   input  wire logic [lcabl_pkg::FIELD_WIDTH-1:0] req_depth,
   input  wire logic [lcabl_pkg::FIELD_WIDTH-1:0] req_other_node,
   output logic                                   rsp_valid,
   output logic      [lcabl_pkg::FIELD_WIDTH-1:0] rsp_ancestor
);

   localparam int FW         = lcabl_pkg::FIELD_WIDTH;
   localparam int AW         = $clog2(MAX_NODES);
   localparam int FIELD_SPAN = 1 << FW;
   localparam int WRAP_STEPS = (MAX_NODES >= FIELD_SPAN) ? 0 :
                               $clog2((FIELD_SPAN + MAX_NODES - 1) / MAX_NODES);

   logic [AW-1:0] node_idx;
   logic [AW-1:0] parent_idx;
   logic [AW-1:0] other_idx;

   // Reduce a node field modulo MAX_NODES by conditional subtraction of
   // shifted copies of the node count; only WRAP_STEPS of them survive.
   function automatic logic [AW-1:0] wrap_node(input logic [FW-1:0] value);
      logic [31:0] rest;
      rest = 32'(value);
      for (int k = FW - 1; k >= 0; k--) begin
         if ((k < WRAP_STEPS) && (rest >= (32'(MAX_NODES) << k))) begin
            rest = rest - (32'(MAX_NODES) << k);
         end
      end
      wrap_node = AW'(rest);
   endfunction

   // Node fields wrap into the table range.
   assign node_idx   = wrap_node(req_node);
   assign parent_idx = wrap_node(req_parent);
   assign other_idx  = wrap_node(req_other_node);

   lcabl_seq #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .op           (req_op),
      .node_idx     (node_idx),
      .parent_idx   (parent_idx),
      .depth        (req_depth),
      .other_idx    (other_idx),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_ancestor (rsp_ancestor)
   );

endmodule

`default_nettype wire
